@@ hw/rtl/mamt_pkg.sv @@
// Shared constants, codes and types of the masked attribute match table.
package mamt_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned EntriesDef    = 16;
  localparam int unsigned HandleBitsDef = 16;

  // Widths of the word fields.
  localparam int unsigned KindW   = 2;
  localparam int unsigned HandleW = 16;
  localparam int unsigned AttrW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam logic [AttrW-1:0] PrivateMaskReset = 32'h0000_0001;

  // Request kinds.
  localparam logic [KindW-1:0] KIND_ADD      = 2'd0;
  localparam logic [KindW-1:0] KIND_DELETE   = 2'd1;
  localparam logic [KindW-1:0] KIND_FIND     = 2'd2;
  localparam logic [KindW-1:0] KIND_SHUTDOWN = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK            = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND     = 2'd1;
  localparam logic [StatusW-1:0] ST_SHUTTING_DOWN = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL          = 2'd3;

  // One result word as it leaves the sequencer.
  typedef struct packed {
    logic               released;
    logic [CountW-1:0]  count;
    logic [HandleW-1:0] found;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

@@ hw/rtl/mamt_store.sv @@
// Entry memory: one write port and one registered read port.
module mamt_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mamt_ctrl.sv @@
// Sequencer: decodes a request, scans the entry memory and compacts it on delete.
module mamt_ctrl #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CNT_W       = 5,
  parameter int unsigned MEM_W       = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic [mamt_pkg::KindW-1:0]     req_kind_i,
  input  logic [mamt_pkg::HandleW-1:0]   req_handle_i,
  input  logic [mamt_pkg::AttrW-1:0]     req_attr_i,
  input  logic [mamt_pkg::AttrW-1:0]     req_mask_i,
  input  logic [mamt_pkg::AttrW-1:0]     private_mask_i,
  output logic                           mem_we_o,
  output logic [IDX_W-1:0]               mem_waddr_o,
  output logic [MEM_W-1:0]               mem_wdata_o,
  output logic                           mem_re_o,
  output logic [IDX_W-1:0]               mem_raddr_o,
  input  logic [MEM_W-1:0]               mem_rdata_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output mamt_pkg::res_t                 res_o
);
  import mamt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       occ_q, occ_d;
  logic                   sd_q, sd_d;
  logic                   pend_q, pend_d;
  logic [CNT_W-1:0]       ptr_q, ptr_d;
  logic [IDX_W-1:0]       pend_idx_q, pend_idx_d;
  logic [KindW-1:0]       kind_q, kind_d;
  logic [HANDLE_BITS-1:0] key_q, key_d;
  logic [AttrW-1:0]       attr_q, attr_d;
  logic [AttrW-1:0]       mask_q, mask_d;
  logic [StatusW-1:0]     status_q, status_d;
  logic [HANDLE_BITS-1:0] found_q, found_d;

  logic [HANDLE_BITS-1:0] in_key;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [AttrW-1:0]       rd_attr;
  logic                   entry_hit;

  assign in_key    = HANDLE_BITS'(32'(req_handle_i));
  assign rd_attr   = mem_rdata_i[AttrW-1:0];
  assign rd_handle = mem_rdata_i[MEM_W-1:AttrW];

  // The word read last cycle is compared against the held request.
  always_comb begin
    if (kind_q == KIND_FIND) begin
      entry_hit = pend_q && ((rd_attr & private_mask_i) == '0)
                  && ((rd_attr & mask_q) == (attr_q & mask_q));
    end else begin
      entry_hit = pend_q && (rd_handle == key_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    sd_d        = sd_q;
    pend_d      = pend_q;
    ptr_d       = ptr_q;
    pend_idx_d  = pend_idx_q;
    kind_d      = kind_q;
    key_d       = key_q;
    attr_d      = attr_q;
    mask_d      = mask_q;
    status_d    = status_q;
    found_d     = found_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = occ_q[IDX_W-1:0];
    mem_wdata_o = {in_key, req_attr_i};
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          kind_d   = req_kind_i;
          key_d    = in_key;
          attr_d   = req_attr_i;
          mask_d   = req_mask_i;
          found_d  = '0;
          status_d = ST_OK;
          ptr_d    = '0;
          pend_d   = 1'b0;
          case (req_kind_i)
            KIND_ADD: begin
              // Shutdown is checked before the table is checked for room.
              if (sd_q) begin
                status_d = ST_SHUTTING_DOWN;
              end else if (occ_q == CNT_W'(ENTRIES)) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                occ_d    = occ_q + CNT_W'(1);
              end
              state_d = S_DONE;
            end
            KIND_DELETE, KIND_FIND: begin
              state_d = S_SCAN;
            end
            default: begin
              sd_d    = 1'b1;
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (entry_hit) begin
          pend_d = 1'b0;
          if (kind_q == KIND_FIND) begin
            found_d = rd_handle;
            state_d = S_DONE;
          end else begin
            ptr_d   = CNT_W'(pend_idx_q) + CNT_W'(1);
            state_d = S_SHIFT;
          end
        end else if (ptr_q < occ_q) begin
          mem_re_o   = 1'b1;
          ptr_d      = ptr_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[IDX_W-1:0];
        end else if (!pend_q) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else begin
          pend_d = 1'b0;
        end
      end

      S_SHIFT: begin
        // Each entry behind the deleted one moves down by one slot; the write
        // always trails the read, so the two never touch the same entry.
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_idx_q - IDX_W'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (ptr_q < occ_q) begin
          mem_re_o   = 1'b1;
          ptr_d      = ptr_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = ptr_q[IDX_W-1:0];
        end else if (!pend_q) begin
          occ_d   = occ_q - CNT_W'(1);
          state_d = S_DONE;
        end else begin
          pend_d = 1'b0;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      occ_q   <= '0;
      sd_q    <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      sd_q    <= sd_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    pend_idx_q <= pend_idx_d;
    kind_q     <= kind_d;
    key_q      <= key_d;
    attr_q     <= attr_d;
    mask_q     <= mask_d;
    status_q   <= status_d;
    found_q    <= found_d;
  end

  assign req_ready_o     = (state_q == S_IDLE);
  assign res_valid_o     = (state_q == S_DONE);
  assign res_o.status    = status_q;
  assign res_o.found     = HandleW'(32'(found_q));
  assign res_o.count     = CountW'(32'(occ_q));
  assign res_o.released  = sd_q && (occ_q == '0);

endmodule

@@ hw/rtl/masked_attribute_match_table.sv @@
// Top level of the masked attribute match table: ports, register and output stage.
//
// An ordered table of up to ENTRIES handle/attribute entries held in one
// synchronous memory. One request word is in work at a time. Add and shutdown
// go from acceptance straight to the done state, and their result word enters
// the output register; the input opens again in that same cycle.
// Find and delete walk the entries oldest first through the single read port,
// one entry per cycle; a find stops at its first hit, and a delete then copies
// the entries behind the removed one down one per cycle. A result word
// waits in the output register while the next request is taken. The memory
// needs no clearing after reset; only entries below the entry count are read.
module masked_attribute_match_table #(
  parameter int unsigned ENTRIES     = mamt_pkg::EntriesDef,
  parameter int unsigned HANDLE_BITS = mamt_pkg::HandleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,     // private_mask
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,    // handle[15:0], attributes[47:16], mask[79:48]
  input  logic [1:0]  s_axis_tuser,    // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata     // status[1:0], found_handle[17:2],
                                       // entry_count[22:18], released[23]
);
  import mamt_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned MEM_W = HANDLE_BITS + AttrW;

  logic [AttrW-1:0] private_mask_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [MEM_W-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             res_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      private_mask_q <= PrivateMaskReset;
    end else if (cfg_we_i) begin
      private_mask_q <= cfg_wdata_i;
    end
  end

  mamt_store #(
    .DEPTH (ENTRIES),
    .WIDTH (MEM_W),
    .AW    (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mamt_ctrl #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .MEM_W       (MEM_W)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_kind_i     (s_axis_tuser),
    .req_handle_i   (s_axis_tdata[15:0]),
    .req_attr_i     (s_axis_tdata[47:16]),
    .req_mask_i     (s_axis_tdata[79:48]),
    .private_mask_i (private_mask_q),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // The output register frees as soon as its word is taken.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.released, res_q.count, res_q.found, res_q.status};

endmodule

@@ hw/rtl/mamt_checker.sv @@
// Port-level checks of the masked attribute match table, bound to the top level.
module mamt_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import mamt_pkg::*;

  logic [StatusW-1:0] out_status;
  logic [HandleW-1:0] out_found;
  logic [CountW-1:0]  out_count;
  logic               out_released;

  assign out_status   = m_axis_tdata[1:0];
  assign out_found    = m_axis_tdata[17:2];
  assign out_count    = m_axis_tdata[22:18];
  assign out_released = m_axis_tdata[23];

  // Only one request is in work, so the input closes right after a word.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted a second word while one was in work");

  a_found_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status != ST_OK) |-> (out_found == '0))
    else $error("found handle is nonzero on a failed request");

  a_released_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_released |-> (out_count == '0))
    else $error("released reported with entries left");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind masked_attribute_match_table mamt_port_checker u_mamt_checker (.*);

@@ tb/mamt_checker.sv @@
// Checker for the match table: predicts each result word from the accepted requests and compares.
module mamt_checker #(
  parameter int unsigned HANDLE_BITS = mamt_pkg::HandleBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [79:0] req_data_i,    // handle[15:0], attributes[47:16], mask[79:48]
  input  logic [1:0]  req_user_i,    // kind[1:0]
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [23:0] res_data_i,    // status[1:0], found_handle[17:2],
                                     // entry_count[22:18], released[23]
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import mamt_pkg::*;

  localparam logic [HandleW-1:0] HandleKeep = HandleW'((64'd1 << HANDLE_BITS) - 64'd1);

  // Shadow copy of the table, oldest entry at index 0.
  logic [HandleW-1:0] tbl_handle [EntriesDef];
  logic [AttrW-1:0]   tbl_attr   [EntriesDef];
  int unsigned        tbl_count = 0;
  logic               shut_flag = 1'b0;
  logic [AttrW-1:0]   priv_mask = PrivateMaskReset;

  res_t        awaited_results [$];
  res_t        got;
  res_t        want;
  int unsigned mismatches = 0;

  // Applies one request to the shadow table and returns the result word it yields.
  function automatic res_t table_apply(input logic [KindW-1:0] kind,
                                       input logic [HandleW-1:0] h,
                                       input logic [AttrW-1:0] attr,
                                       input logic [AttrW-1:0] msk);
    res_t r;
    int   hit;
    int   i;
    r        = '0;
    r.status = ST_OK;
    hit      = -1;
    case (kind)
      KIND_ADD: begin
        if (shut_flag) begin
          r.status = ST_SHUTTING_DOWN;
        end else if (tbl_count >= EntriesDef) begin
          r.status = ST_FULL;
        end else begin
          tbl_handle[tbl_count] = h;
          tbl_attr[tbl_count]   = attr;
          tbl_count++;
        end
      end
      KIND_DELETE: begin
        for (i = 0; i < int'(tbl_count); i++) begin
          if (hit < 0 && tbl_handle[i] == h) hit = i;
        end
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // Close the gap so the remaining entries keep their order.
          for (i = hit; i + 1 < int'(tbl_count); i++) begin
            tbl_handle[i] = tbl_handle[i + 1];
            tbl_attr[i]   = tbl_attr[i + 1];
          end
          tbl_count--;
        end
      end
      KIND_FIND: begin
        for (i = 0; i < int'(tbl_count); i++) begin
          if (hit < 0 && (tbl_attr[i] & priv_mask) == '0 &&
              (tbl_attr[i] & msk) == (attr & msk)) hit = i;
        end
        if (hit < 0) r.status = ST_NOT_FOUND;
        else r.found = tbl_handle[hit];
      end
      default: begin
        shut_flag = 1'b1;
      end
    endcase
    r.count    = tbl_count[CountW-1:0];
    r.released = shut_flag && tbl_count == 0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_count  = 0;
      shut_flag  = 1'b0;
      priv_mask  = PrivateMaskReset;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) priv_mask = cfg_wdata_i;
      // A result word can never belong to a request accepted at the same edge,
      // so the oldest expectation is taken before the new one is added.
      if (res_valid_i && res_ready_i) begin
        got = res_t'(res_data_i);
        if (awaited_results.size() == 0) begin
          $error("result word %h arrived with no request waiting", res_data_i);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
          end
          if (got.found !== want.found) begin
            $error("found_handle: expected %h, actual %h", want.found, got.found);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, got.count);
            mismatches++;
          end
          if (got.released !== want.released) begin
            $error("released: expected %0d, actual %0d", want.released, got.released);
            mismatches++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        awaited_results.push_back(table_apply(req_user_i, req_data_i[15:0] & HandleKeep,
                                              req_data_i[47:16], req_data_i[79:48]));
      end
      pending_o <= awaited_results.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the match table testbench: clock, reset, request and result traffic, and the verdict.
module tb_top;
  import mamt_pkg::*;

  localparam int unsigned HoldCycles = 500;
  localparam int unsigned StallLimit = 4000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [31:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned stall_cycles = 0;
  int unsigned results_seen = 0;
  res_t        last_result  = '0;

  // Recently added handles and attributes, used to aim deletes and finds at real entries.
  logic [HandleW-1:0] recent_h [16];
  logic [AttrW-1:0]   recent_a [16];
  int unsigned        recent_n  = 0;
  bit                 steady    = 1'b0;
  bit                 shut_sent = 1'b0;

  masked_attribute_match_table #(
    .ENTRIES    (EntriesDef),
    .HANDLE_BITS(HandleBitsDef)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  mamt_checker #(
    .HANDLE_BITS(HandleBitsDef)
  ) table_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (s_axis_tvalid),
    .req_ready_i (s_axis_tready),
    .req_data_i  (s_axis_tdata),
    .req_user_i  (s_axis_tuser),
    .res_valid_i (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_i  (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      last_result  <= res_t'(m_axis_tdata);
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned recent_pick();
    return $urandom_range(0, (recent_n < 16 ? recent_n : 16) - 1);
  endfunction

  function automatic logic [HandleW-1:0] any_handle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return HandleW'($urandom_range(0, 15));
    if (r < 65) return '1;
    if (r < 70) return '0;
    return HandleW'($urandom);
  endfunction

  function automatic logic [HandleW-1:0] known_handle();
    if (recent_n != 0 && $urandom_range(0, 3) != 0) return recent_h[recent_pick()];
    return any_handle();
  endfunction

  function automatic logic [AttrW-1:0] any_attr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    return $urandom;
  endfunction

  // Mostly the word of a stored entry, now and then with one bit flipped.
  function automatic logic [AttrW-1:0] known_attr();
    logic [AttrW-1:0] a;
    int unsigned      b;
    if (recent_n == 0 || $urandom_range(0, 9) < 3) return any_attr();
    a = recent_a[recent_pick()];
    if ($urandom_range(0, 3) == 0) begin
      b    = $urandom_range(0, AttrW - 1);
      a[b] = ~a[b];
    end
    return a;
  endfunction

  function automatic logic [AttrW-1:0] any_mask();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return '1;
    if (r < 70) return $urandom;
    return $urandom & $urandom & $urandom;
  endfunction

  // Offers one request word, after a random gap unless steady is set, and waits until it is taken.
  task automatic offer(input logic [KindW-1:0] kind, input logic [HandleW-1:0] h,
                       input logic [AttrW-1:0] attr, input logic [AttrW-1:0] msk);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {msk, attr, h};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (kind == KIND_ADD && !shut_sent) begin
      recent_h[recent_n % 16] = h;
      recent_a[recent_n % 16] = attr;
      recent_n++;
    end
  endtask

  // Stops offering and waits until every result word has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_private_mask(input logic [AttrW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Unused fields of each request carry random noise.
  task automatic random_request(input int unsigned add_w, input int unsigned del_w,
                                input int unsigned find_w);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < add_w) begin
      offer(KIND_ADD, any_handle(), any_attr(), $urandom);
    end else if (r < add_w + del_w) begin
      offer(KIND_DELETE, known_handle(), $urandom, $urandom);
    end else if (r < add_w + del_w + find_w) begin
      offer(KIND_FIND, HandleW'($urandom), known_attr(), any_mask());
    end else begin
      offer(KIND_SHUTDOWN, HandleW'($urandom), $urandom, $urandom);
    end
  endtask

  // Result side: random ready pattern, calm stretches, and two long hold-offs.
  initial begin
    int unsigned holds;
    int unsigned r;
    holds = 0;
    @(posedge clk_i);
    forever begin
      if ((holds == 0 && results_seen >= 300) || (holds == 1 && results_seen >= 1200)) begin
        holds++;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(50, 200)) @(posedge clk_i);
        end else if (r < 60) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end else begin
          m_axis_tready <= 1'b0;
          repeat (r < 94 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    int unsigned      p;
    int unsigned      k;
    bit               emptied;
    logic [AttrW-1:0] pm;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset private mask.
    offer(KIND_FIND, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    offer(KIND_DELETE, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(KIND_ADD, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
    offer(KIND_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    offer(KIND_ADD, 16'h1234, 32'hA5A5_A5A4, 32'h0000_0000);
    offer(KIND_ADD, 16'h0000, 32'h0000_0002, 32'h0000_0000);
    offer(KIND_FIND, 16'hFFFF, 32'h0000_0000, 32'h0000_0000);
    // The only all-ones entry is private, so this find misses.
    offer(KIND_FIND, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(KIND_FIND, 16'h0000, 32'hA5A5_A5A4, 32'hFFFF_FFFF);
    // Duplicate handle: the oldest copy goes.
    offer(KIND_DELETE, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    offer(KIND_FIND, 16'h0000, 32'h0000_0000, 32'h0000_0000);
    offer(KIND_DELETE, 16'h5555, 32'h0000_0000, 32'h0000_0000);
    repeat (14) offer(KIND_ADD, HandleW'($urandom_range(16, 31)), $urandom, '0);
    offer(KIND_DELETE, 16'h1234, $urandom, $urandom);

    for (p = 0; p < 8; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1:       pm = '0;
          2:       pm = '1;
          4:       pm = 32'h8000_0000;
          6:       pm = PrivateMaskReset;
          default: pm = $urandom;
        endcase
        set_private_mask(pm);
      end
      steady = (p == 3 || p == 6);
      if (p % 2 == 0) repeat (200) random_request(45, 25, 30);
      else repeat (200) random_request(25, 40, 35);
    end
    steady = 1'b0;

    // Shutdown phase: fill up, shut down, then empty the table by finding and
    // deleting the oldest entry until nothing is left.
    drain();
    set_private_mask('0);
    repeat (18) offer(KIND_ADD, any_handle(), any_attr(), $urandom);
    offer(KIND_SHUTDOWN, HandleW'($urandom), $urandom, $urandom);
    shut_sent = 1'b1;
    offer(KIND_ADD, any_handle(), any_attr(), $urandom);
    offer(KIND_FIND, HandleW'($urandom), known_attr(), any_mask());
    drain();
    emptied = 1'b0;
    k       = 0;
    while (!emptied && k < 20) begin
      offer(KIND_FIND, HandleW'($urandom), $urandom, '0);
      drain();
      if (last_result.status == ST_OK) begin
        offer(KIND_DELETE, last_result.found, $urandom, $urandom);
        drain();
      end else begin
        emptied = 1'b1;
      end
      k++;
    end
    offer(KIND_SHUTDOWN, HandleW'($urandom), $urandom, $urandom);
    drain();
    set_private_mask($urandom);
    repeat (120) random_request(20, 30, 30);

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
